### src/nbr_pkg.sv
package nbr_pkg;

   // Request kinds.
   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_SYNC  = 2'd1;
   localparam logic [1:0] REQ_RESET = 2'd2;
   localparam logic [1:0] REQ_LOAD  = 2'd3;

   // Bus phase codes.
   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_SLOW  = 3'd1;
   localparam logic [2:0] PH_SMID  = 3'd2;
   localparam logic [2:0] PH_SHIGH = 3'd3;
   localparam logic [2:0] PH_DHI   = 3'd4;
   localparam logic [2:0] PH_DLO   = 3'd5;
   localparam logic [2:0] PH_POST  = 3'd6;

   localparam int ROM_ADDR_W = 8;
   localparam int ROM_DEPTH  = 1 << ROM_ADDR_W;

   typedef struct packed {
      logic                  en;
      logic [ROM_ADDR_W-1:0] addr;
      logic [7:0]            data;
   } rom_wr_type;

   typedef struct packed {
      logic       active;
      logic [3:0] nibble;
   } drive_type;

   // Contents of an entry that has never been loaded since reset.
   function automatic logic [7:0] fixture_byte(input logic [ROM_ADDR_W-1:0] addr);
      logic [7:0] b;
      b = 8'h00;
      if (addr[ROM_ADDR_W-1:4] == '0) begin
         case (addr[3:0])
            4'h0: b = 8'h12;
            4'h1: b = 8'h34;
            4'h2: b = 8'h56;
            4'h3: b = 8'h78;
            4'h4: b = 8'h9A;
            4'h5: b = 8'hBC;
            4'h6: b = 8'hDE;
            4'h7: b = 8'hF0;
            4'h8: b = 8'h11;
            4'h9: b = 8'h22;
            4'hA: b = 8'h33;
            4'hB: b = 8'h44;
            4'hC: b = 8'h55;
            4'hD: b = 8'h66;
            4'hE: b = 8'h77;
            4'hF: b = 8'h88;
            default: b = 8'h00;
         endcase
      end
      return b;
   endfunction

endpackage

### src/nbr_rom.sv
module nbr_rom (
   input  logic                           clock,
   input  logic                           reset,
   input  nbr_pkg::rom_wr_type            wr,
   input  logic [nbr_pkg::ROM_ADDR_W-1:0] rd_addr,
   output logic [7:0]                     rd_byte
);

   logic [7:0]                     mem_ff [nbr_pkg::ROM_DEPTH];
   logic [nbr_pkg::ROM_DEPTH-1:0]  valid_ff;
   logic [7:0]                     rd_data_ff;
   logic                           rd_valid_ff;
   logic                           hit_ff;
   logic [7:0]                     wr_data_ff;
   logic [nbr_pkg::ROM_ADDR_W-1:0] addr_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem_ff[rd_addr];
      wr_data_ff <= wr.data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
         hit_ff      <= 1'b0;
         addr_ff     <= '0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
         hit_ff      <= wr.en && (wr.addr == rd_addr);
         addr_ff     <= rd_addr;
      end
   end

   // A write to the address being read in the same cycle is forwarded.
   assign rd_byte = hit_ff      ? wr_data_ff :
                    rd_valid_ff ? rd_data_ff : nbr_pkg::fixture_byte(addr_ff);

endmodule

### src/nbr_seq.sv
module nbr_seq (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           go,
   input  logic [1:0]                     req_kind,
   input  logic [3:0]                     nibble,
   input  logic [7:0]                     load_address,
   input  logic [7:0]                     load_byte,
   input  logic [3:0]                     chip_number,
   input  logic [7:0]                     rom_byte,
   output nbr_pkg::rom_wr_type            rom_wr,
   output logic [nbr_pkg::ROM_ADDR_W-1:0] rom_rd_addr,
   output nbr_pkg::drive_type             drive_next
);

   logic [2:0]         phase_ff, phase_in;
   logic [3:0]         lo_nib_ff, lo_nib_in;
   logic [3:0]         mid_nib_ff, mid_nib_in;
   logic [3:0]         hi_nib_ff, hi_nib_in;
   nbr_pkg::drive_type drive_ff, drive_in;

   always_comb begin
      phase_in    = phase_ff;
      lo_nib_in   = lo_nib_ff;
      mid_nib_in  = mid_nib_ff;
      hi_nib_in   = hi_nib_ff;
      drive_in    = drive_ff;
      rom_wr.en   = 1'b0;
      rom_wr.addr = load_address;
      rom_wr.data = load_byte;
      if (go) begin
         case (req_kind)
            nbr_pkg::REQ_TICK: begin
               case (phase_ff)
                  nbr_pkg::PH_SLOW: begin
                     lo_nib_in = nibble;
                     phase_in  = nbr_pkg::PH_SMID;
                  end
                  nbr_pkg::PH_SMID: begin
                     mid_nib_in = nibble;
                     phase_in   = nbr_pkg::PH_SHIGH;
                  end
                  nbr_pkg::PH_SHIGH, nbr_pkg::PH_DHI: begin
                     if (phase_ff == nbr_pkg::PH_SHIGH) begin
                        hi_nib_in = nibble;
                     end
                     if (hi_nib_in == chip_number) begin
                        drive_in.active = 1'b1;
                        drive_in.nibble = rom_byte[7:4];
                     end else begin
                        drive_in.active = 1'b0;
                     end
                     phase_in = nbr_pkg::PH_DLO;
                  end
                  nbr_pkg::PH_DLO: begin
                     if (hi_nib_ff == chip_number) begin
                        drive_in.active = 1'b1;
                        drive_in.nibble = rom_byte[3:0];
                     end else begin
                        drive_in.active = 1'b0;
                     end
                     phase_in = nbr_pkg::PH_POST;
                  end
                  default: begin
                     // Idle and post phases leave the bus released.
                     drive_in.active = 1'b0;
                  end
               endcase
            end
            nbr_pkg::REQ_SYNC: begin
               phase_in = nbr_pkg::PH_SLOW;
            end
            nbr_pkg::REQ_RESET: begin
               phase_in        = nbr_pkg::PH_IDLE;
               drive_in.active = 1'b0;
            end
            default: begin
               rom_wr.en = 1'b1;
            end
         endcase
      end
   end

   // The ROM is read ahead at the address that will hold after this edge.
   assign rom_rd_addr = {mid_nib_in, lo_nib_in};
   assign drive_next  = drive_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= nbr_pkg::PH_IDLE;
         lo_nib_ff  <= '0;
         mid_nib_ff <= '0;
         hi_nib_ff  <= '0;
         drive_ff   <= '0;
      end else begin
         phase_ff   <= phase_in;
         lo_nib_ff  <= lo_nib_in;
         mid_nib_ff <= mid_nib_in;
         hi_nib_ff  <= hi_nib_in;
         drive_ff   <= drive_in;
      end
   end

endmodule

### src/nibble_bus_rom_phase_machine.sv
// A request's response passes through the input register, then the response register,
// and a stalled response holds it there.
// Throughput: one request per cycle unless a response stalls; the ROM read is issued
// early from the next latch values, so drive phases never wait on the memory port.
// Reset: synchronous; clears the phase, address latches, drive state and chip number,
// and marks every ROM entry as holding its power-up contents. No clearing pass is run.
module nibble_bus_rom_phase_machine (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_type,
   input  logic [3:0] req_bus_nibble,
   input  logic [7:0] req_load_address,
   input  logic [7:0] req_load_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_bus_drive,
   output logic [3:0] rsp_bus_value,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [3:0] csr_chip_number
);

   logic       in_valid_ff, in_valid_in;
   logic [1:0] in_kind_ff;
   logic [3:0] in_nibble_ff;
   logic [7:0] in_addr_ff;
   logic [7:0] in_byte_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_drive_ff;
   logic [3:0] rsp_value_ff;
   logic [3:0] chip_ff;
   logic       advance;
   logic       go;
   logic       accept;

   nbr_pkg::rom_wr_type            rom_wr;
   logic [nbr_pkg::ROM_ADDR_W-1:0] rom_rd_addr;
   logic [7:0]                     rom_byte;
   nbr_pkg::drive_type             drive_next;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign go        = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (go) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (go) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         chip_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            chip_ff <= csr_chip_number;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_kind_ff   <= req_type;
         in_nibble_ff <= req_bus_nibble;
         in_addr_ff   <= req_load_address;
         in_byte_ff   <= req_load_byte;
      end
      if (go) begin
         rsp_drive_ff <= drive_next.active;
         rsp_value_ff <= drive_next.active ? drive_next.nibble : 4'h0;
      end
   end

   nbr_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .go           (go),
      .req_kind     (in_kind_ff),
      .nibble       (in_nibble_ff),
      .load_address (in_addr_ff),
      .load_byte    (in_byte_ff),
      .chip_number  (chip_ff),
      .rom_byte     (rom_byte),
      .rom_wr       (rom_wr),
      .rom_rd_addr  (rom_rd_addr),
      .drive_next   (drive_next)
   );

   nbr_rom u_rom (
      .clock   (clock),
      .reset   (reset),
      .wr      (rom_wr),
      .rd_addr (rom_rd_addr),
      .rd_byte (rom_byte)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bus_drive = rsp_drive_ff;
   assign rsp_bus_value = rsp_value_ff;

endmodule

### src/nbr_checker.sv
module nbr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [1:0] req_type,
   input logic [3:0] req_bus_nibble,
   input logic [7:0] req_load_address,
   input logic [7:0] req_load_byte,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_bus_drive,
   input logic [3:0] rsp_bus_value
);

   // A released bus always reads as zero.
   a_released_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_bus_drive) |-> (rsp_bus_value == 4'h0))
      else $error("released bus shows a non-zero value");

   // No response may be pending straight after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   // Requests are held back only while a response is itself held back.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a stalled response");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_bus_drive) && $stable(rsp_bus_value)))
      else $error("stalled response changed");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=>
         (req_valid && $stable(req_type) && $stable(req_bus_nibble) &&
          $stable(req_load_address) && $stable(req_load_byte)))
      else $error("stalled request changed");

endmodule

bind nibble_bus_rom_phase_machine nbr_checker u_nbr_checker (.*);
